// ===== src/dfc_pkg.sv =====
// Shared constants and types for the disparity to false colour core.
// No dependencies; imported by the channel interfaces and the core.
package dfc_pkg;

  // Field widths
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned BF_W    = 24;
  // 40 * (2^24 - 1) fits in 30 bits
  localparam int unsigned NUM_W   = 30;
  // Quarter-pixel and half-code disparities both fit in 7 bits
  localparam int unsigned DISP_W  = 7;
  localparam int unsigned QUO_W   = 8;

  localparam logic [BF_W-1:0] BF_RESET = 24'd97280;
  localparam logic [CODE_W-1:0] CODE_HALF_MIN = 8'd128;
  localparam logic [DISP_W-1:0] DISP_OFFSET = 7'd32;

  // Colour bins: depth is scaled by 1000 and compared with bounds times 255
  localparam int unsigned SCALED_W    = 18;
  localparam int unsigned FRAC_NUM_W  = 16;
  localparam int unsigned RECIP_W     = 18;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned DEPTH_SCALE = 1000;
  localparam int unsigned NUM_BINS    = 7;

  typedef logic [2:0] bin_t;
  // Colour bit 2 is red, bit 1 green, bit 0 blue
  typedef logic [2:0] rgb_t;

  localparam int unsigned BIN_LO_SCALED [NUM_BINS] = '{
    0 * 255, 114 * 255, 299 * 255, 413 * 255, 587 * 255, 701 * 255, 886 * 255
  };
  localparam int unsigned BIN_HI_SCALED [NUM_BINS] = '{
    114 * 255, 299 * 255, 413 * 255, 587 * 255, 701 * 255, 886 * 255, 1000 * 255
  };
  localparam int unsigned BIN_SPAN [NUM_BINS] = '{
    114, 185, 114, 174, 114, 185, 114
  };
  // ceil(2^24 / span): exact floor division for numerators below 2^16
  localparam int unsigned BIN_RECIP [NUM_BINS] = '{
    ((1 << 24) + 113) / 114, ((1 << 24) + 184) / 185, ((1 << 24) + 113) / 114,
    ((1 << 24) + 173) / 174, ((1 << 24) + 113) / 114, ((1 << 24) + 184) / 185,
    ((1 << 24) + 113) / 114
  };
  // End colours: black, blue, red, magenta, green, cyan, yellow, white
  localparam rgb_t BIN_RGB [NUM_BINS+1] = '{
    3'b000, 3'b001, 3'b100, 3'b101, 3'b010, 3'b011, 3'b110, 3'b111
  };

endpackage

// ===== src/dfc_if.sv =====
// Valid/ready channel interfaces for pixels in, colours out and configuration.
// Depends on dfc_pkg for the field widths.
interface dfc_pix_if import dfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] disparity_code;

  modport source (output valid, output disparity_code, input ready);
  modport sink   (input valid, input disparity_code, output ready);
endinterface

interface dfc_color_if import dfc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] depth_byte;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;

  modport source (output valid, output depth_byte, output red, output green,
                  output blue, input ready);
  modport sink   (input valid, input depth_byte, input red, input green,
                  input blue, output ready);
endinterface

interface dfc_cfg_if import dfc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [BF_W-1:0] baseline_focal_q8;

  modport source (output valid, output baseline_focal_q8, input ready);
  modport sink   (input valid, input baseline_focal_q8, output ready);
endinterface

// ===== src/disparity_to_false_color_core.sv =====
// Disparity to false colour core: pipelined depth decode, divider and colour map.
// Depends on dfc_pkg and the channel interfaces in dfc_if.sv.
//
// Usage
//   pix_i carries one coded disparity byte per request. color_o returns, per
//   request and in order, the display depth byte and its false-colour RGB.
//   cfg_i writes baseline times focal length (BF_FRAC_BITS fraction bits); it
//   is always ready and should only be written while the pipeline is empty.
//   Requests pass through 13 register stages to color_o. Throughput is one
//   pixel per cycle while color_o.ready is high: one decode stage, one
//   saturation stage, eight restoring-divider stages (one quotient bit
//   each), then a bin-select stage, a reciprocal-multiply stage and the
//   output register.
//   Each stage has its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles close up under a stall.
//   When color_o.ready is low the result holds and the pipeline fills; pix_i
//   stays ready until every stage is occupied. Nothing is dropped or repeated.
//   Reset empties the pipeline and loads the register with 380.0.
module disparity_to_false_color_core import dfc_pkg::*; #(
  parameter int unsigned BF_FRAC_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  dfc_pix_if.sink     pix_i,
  dfc_color_if.source color_o,
  dfc_cfg_if.sink     cfg_i
);

  localparam int unsigned DW = DISP_W + BF_FRAC_BITS;
  localparam int unsigned CW = (DW + QUO_W > NUM_W) ? DW + QUO_W : NUM_W;
  localparam int unsigned L  = 13;
  localparam int unsigned S_SAT  = 1;
  localparam int unsigned S_DIV0 = 2;
  localparam int unsigned S_DIVN = 9;
  localparam int unsigned S_BIN  = 10;
  localparam int unsigned S_MUL  = 11;
  localparam int unsigned S_OUT  = 12;

  logic [BF_W-1:0] bf_q;
  logic [L-1:0]    vld_q;
  logic [L-1:0]    en;

  // Configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bf_q <= BF_RESET;
    end else if (cfg_i.valid) begin
      bf_q <= cfg_i.baseline_focal_q8;
    end
  end

  // Stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[L-1] = !vld_q[L-1] || color_o.ready;
    for (int k = L - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign pix_i.ready = en[0];

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= pix_i.valid;
      end
      for (int k = 1; k < L; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 0: decode code into numerator and shifted disparity
  logic [NUM_W-1:0]  num_d;
  logic [DISP_W-1:0] disp_d;
  logic [NUM_W-1:0]  num0_q;
  logic [DW-1:0]     den0_q;

  always_comb begin
    if (pix_i.disparity_code == '0) begin
      num_d  = '0;
      disp_d = DISP_W'(1);
    end else if (pix_i.disparity_code < CODE_HALF_MIN) begin
      num_d  = (NUM_W'(bf_q) << 5) + (NUM_W'(bf_q) << 3);
      disp_d = pix_i.disparity_code[DISP_W-1:0];
    end else begin
      num_d  = (NUM_W'(bf_q) << 3) + (NUM_W'(bf_q) << 1);
      disp_d = pix_i.disparity_code[CODE_W-1:1] - DISP_OFFSET;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      num0_q <= num_d;
      den0_q <= DW'(disp_d) << BF_FRAC_BITS;
    end
  end

  // Stage 1 checks for saturation; divider stages: restoring division, one quotient bit a stage
  logic [CW-1:0]    rem_q [S_SAT:S_DIVN];
  logic [DW-1:0]    den_q [S_SAT:S_DIVN];
  logic [QUO_W-1:0] quo_q [S_SAT:S_DIVN];
  logic             sat_q [S_SAT:S_DIVN];

  always_ff @(posedge clk_i) begin
    if (en[S_SAT]) begin
      rem_q[S_SAT] <= CW'(num0_q);
      den_q[S_SAT] <= den0_q;
      quo_q[S_SAT] <= '0;
      sat_q[S_SAT] <= CW'(num0_q) >= (CW'(den0_q) << QUO_W);
    end
  end

  for (genvar s = S_DIV0; s <= S_DIVN; s++) begin : g_div
    localparam int unsigned B = S_DIVN - s;
    logic [CW-1:0] shifted;
    logic          take;

    assign shifted = CW'(den_q[s-1]) << B;
    assign take    = rem_q[s-1] >= shifted;

    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        rem_q[s] <= take ? rem_q[s-1] - shifted : rem_q[s-1];
        den_q[s] <= den_q[s-1];
        quo_q[s] <= quo_q[s-1] | (QUO_W'(take) << B);
        sat_q[s] <= sat_q[s-1];
      end
    end
  end

  // Bin stage: saturate depth, find colour bin, form numerators
  logic [PIX_W-1:0]      depth_c;
  logic [SCALED_W-1:0]   scaled_c;
  bin_t                  bin_c;
  logic [FRAC_NUM_W-1:0] numf_c;
  logic [FRAC_NUM_W-1:0] numc_c;

  logic [PIX_W-1:0]      dep_a_q;
  bin_t                  bin_a_q;
  logic [FRAC_NUM_W-1:0] numf_a_q;
  logic [FRAC_NUM_W-1:0] numc_a_q;
  logic [RECIP_W-1:0]    rcp_a_q;

  always_comb begin
    depth_c  = sat_q[S_DIVN] ? '1 : quo_q[S_DIVN];
    scaled_c = SCALED_W'(depth_c) * SCALED_W'(DEPTH_SCALE);
    bin_c    = bin_t'(NUM_BINS - 1);
    for (int i = NUM_BINS - 2; i >= 0; i--) begin
      if (scaled_c < SCALED_W'(BIN_HI_SCALED[i])) begin
        bin_c = bin_t'(i);
      end
    end
    numf_c = FRAC_NUM_W'(scaled_c - SCALED_W'(BIN_LO_SCALED[bin_c]));
    numc_c = numf_c + FRAC_NUM_W'(BIN_SPAN[bin_c] - 1);
  end

  always_ff @(posedge clk_i) begin
    if (en[S_BIN]) begin
      dep_a_q  <= depth_c;
      bin_a_q  <= bin_c;
      numf_a_q <= numf_c;
      numc_a_q <= numc_c;
      rcp_a_q  <= RECIP_W'(BIN_RECIP[bin_c]);
    end
  end

  // Multiply stage: floor and ceiling quotients by reciprocal
  localparam int unsigned PW = FRAC_NUM_W + RECIP_W;
  logic [PW-1:0]    prodf;
  logic [PW-1:0]    prodc;
  logic [PIX_W-1:0] dep_b_q;
  bin_t             bin_b_q;
  logic [PIX_W-1:0] qf_b_q;
  logic [PIX_W-1:0] qc_b_q;

  assign prodf = PW'(numf_a_q) * PW'(rcp_a_q);
  assign prodc = PW'(numc_a_q) * PW'(rcp_a_q);

  always_ff @(posedge clk_i) begin
    if (en[S_MUL]) begin
      dep_b_q <= dep_a_q;
      bin_b_q <= bin_a_q;
      qf_b_q  <= prodf[RECIP_SHIFT +: PIX_W];
      qc_b_q  <= prodc[RECIP_SHIFT +: PIX_W];
    end
  end

  // Output stage: pick each channel from its bin's end colours
  rgb_t             lo_rgb;
  rgb_t             hi_rgb;
  logic [PIX_W-1:0] chan [3];
  logic [PIX_W-1:0] dep_o_q;
  logic [PIX_W-1:0] red_q;
  logic [PIX_W-1:0] green_q;
  logic [PIX_W-1:0] blue_q;

  always_comb begin
    lo_rgb = BIN_RGB[bin_b_q];
    hi_rgb = BIN_RGB[bin_b_q + bin_t'(1)];
    for (int k = 0; k < 3; k++) begin
      if (lo_rgb[k] == hi_rgb[k]) begin
        chan[k] = lo_rgb[k] ? '1 : '0;
      end else if (hi_rgb[k]) begin
        chan[k] = qf_b_q;
      end else begin
        chan[k] = ~qc_b_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[S_OUT]) begin
      dep_o_q <= dep_b_q;
      red_q   <= chan[2];
      green_q <= chan[1];
      blue_q  <= chan[0];
    end
  end

  assign color_o.valid      = vld_q[S_OUT];
  assign color_o.depth_byte = dep_o_q;
  assign color_o.red        = red_q;
  assign color_o.green      = green_q;
  assign color_o.blue       = blue_q;

  // Checks
  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[S_OUT] |-> pix_i.ready)
    else $error("input not ready with an empty output stage");

  a_zero_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (color_o.valid && color_o.depth_byte == '0) |->
      (color_o.red == '0 && color_o.green == '0 && color_o.blue == '0))
    else $error("zero depth not mapped to black");

  a_full_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (color_o.valid && color_o.depth_byte == '1) |->
      (color_o.red == '1 && color_o.green == '1 && color_o.blue == '1))
    else $error("full-scale depth not mapped to white");

  a_stall_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[S_OUT] && !color_o.ready) |=> vld_q[S_OUT])
    else $error("result lost under stall");

endmodule
